@@ rtl/skset_pkg.sv @@
// Package for the sorted key set: operation codes, field widths and
// parameter defaults. No dependencies; every other file imports it.
`default_nettype none

package skset_pkg;

    // Field widths of the request and response channels.
    localparam int KEY_IN_W  = 16;
    localparam int COUNT_W   = 5;
    localparam int OP_W      = 2;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 16;

    // Operation codes. The fourth code means nothing and leaves the store alone.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

endpackage : skset_pkg

`default_nettype wire

@@ rtl/skset_req_if.sv @@
// Request channel of the sorted key set: valid/ready plus operation and key.
// Depends on skset_pkg.
`default_nettype none

interface skset_req_if;
    import skset_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [KEY_IN_W-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);

endinterface : skset_req_if

`default_nettype wire

@@ rtl/skset_rsp_if.sv @@
// Response channel of the sorted key set: valid/ready plus found, status, count.
// Depends on skset_pkg.
`default_nettype none

interface skset_rsp_if;
    import skset_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output found, output status, output count, input ready);
    modport sink   (input valid, input found, input status, input count, output ready);

endinterface : skset_rsp_if

`default_nettype wire

@@ rtl/skset_cell.sv @@
// One storage cell of the sorted key chain: holds a key, compares it with the
// request key and shifts in its lower neighbor's key on insert. Uses skset_pkg.
`default_nettype none

module skset_cell #(
    parameter int KEY_WIDTH = 16,
    parameter int CNT_W     = 5,
    parameter int INDEX     = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_ins,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic [CNT_W-1:0]     i_count,
    input  wire logic [KEY_WIDTH-1:0] i_prev_key,
    input  wire logic                 i_prev_ge,
    output logic      [KEY_WIDTH-1:0] o_key,
    output logic                      o_ge,
    output logic                      o_match
);
    import skset_pkg::*;

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 w_valid;

    // The cell holds a live key when its place lies below the fill count.
    assign w_valid = (i_count > CNT_W'(INDEX));

    // A free cell counts as not smaller, so the insert point never passes the count.
    assign o_ge    = !w_valid || (r_key >= i_key);
    assign o_match = w_valid && (r_key == i_key);
    assign o_key   = r_key;

    // On insert: cells above the insert point take the neighbor's key, the
    // cell at the insert point takes the new key, cells below hold.
    always_comb begin
        n_key = r_key;
        if (i_ins) begin
            if (i_prev_ge) begin
                n_key = i_prev_key;
            end else if (o_ge) begin
                n_key = i_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule : skset_cell

`default_nettype wire

@@ rtl/sorted_key_set_core.sv @@
// Sorted key set: request port, fill count, output register and the chain of
// storage cells. Uses skset_pkg, skset_req_if, skset_rsp_if and skset_cell.
// Response: registered; it appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the response is drained; every cell
// compares and shifts in parallel.
// Reset: synchronous, active low; empties the store and clears the response valid flag.
`default_nettype none

module sorted_key_set_core #(
    parameter int CAPACITY  = skset_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = skset_pkg::KEY_WIDTH_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    skset_req_if.sink   i_req,
    skset_rsp_if.source o_rsp
);
    import skset_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 r_found;
    logic                 r_status;
    logic [COUNT_W-1:0]   r_cnt_out;
    logic                 n_found;
    logic                 n_status;
    logic [COUNT_W-1:0]   w_cnt_out;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_ins;
    logic [KEY_WIDTH-1:0] w_key;
    logic [KEY_WIDTH-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0]  w_cell_ge;
    logic [CAPACITY-1:0]  w_cell_match;

    // Request handshake: a new request enters while the response slot is free
    // or being drained, and never while reset is held.
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));

    // Fit the request key to the stored key width.
    generate
        if (KEY_WIDTH <= KEY_IN_W) begin : g_key_trunc
            assign w_key = i_req.key[KEY_WIDTH-1:0];
        end else begin : g_key_ext
            assign w_key = {{(KEY_WIDTH - KEY_IN_W){1'b0}}, i_req.key};
        end
    endgenerate

    assign w_ins = w_accept && (i_req.operation == OP_INSERT) && !w_full;

    // Chain of cells; each one sees its lower neighbor's key and compare flag.
    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [KEY_WIDTH-1:0] w_prev_key;
            logic                 w_prev_ge;
            if (gi == 0) begin : g_first
                assign w_prev_key = w_key;
                assign w_prev_ge  = 1'b0;
            end else begin : g_rest
                assign w_prev_key = w_cell_key[gi-1];
                assign w_prev_ge  = w_cell_ge[gi-1];
            end
            skset_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .CNT_W     (CNT_W),
                .INDEX     (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ins      (w_ins),
                .i_key      (w_key),
                .i_count    (r_count),
                .i_prev_key (w_prev_key),
                .i_prev_ge  (w_prev_ge),
                .o_key      (w_cell_key[gi]),
                .o_ge       (w_cell_ge[gi]),
                .o_match    (w_cell_match[gi])
            );
        end
    endgenerate

    // Next fill count and response fields for the request being accepted.
    always_comb begin
        n_count  = r_count;
        n_found  = 1'b0;
        n_status = 1'b0;
        case (i_req.operation)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_LOOKUP: begin
                n_found = |w_cell_match;
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Report the count after the request in the response field: its low bits, or zero-extended.
    generate
        if (CNT_W >= COUNT_W) begin : g_cnt_trunc
            assign w_cnt_out = n_count[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_cnt_out = {{(COUNT_W - CNT_W){1'b0}}, n_count};
        end
    endgenerate

    // Fill count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_found   <= n_found;
            r_status  <= n_status;
            r_cnt_out <= w_cnt_out;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.found  = r_found;
    assign o_rsp.status = r_status;
    assign o_rsp.count  = r_cnt_out;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // A clear request leaves the store empty.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_req.operation == OP_CLEAR) |=> (r_count == '0))
        else $error("store not empty after clear");

    // An insert into a full store is dropped and flagged.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_req.operation == OP_INSERT) && w_full
        |=> r_status && (r_count == CNT_W'(CAPACITY)))
        else $error("insert into full store not flagged");

    // A response never reports both a hit and a dropped insert.
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_found && r_status))
        else $error("found and status both set");

endmodule : sorted_key_set_core

`default_nettype wire
